@@ rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared codes and types for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Command kinds carried by an input word
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_WRITE   = 2'd2;
  localparam logic [1:0] KIND_RECOVER = 2'd3;

  // Completion status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ADDR_NACK = 3'd1;
  localparam logic [2:0] ST_REG_NACK  = 3'd2;
  localparam logic [2:0] ST_DATA_NACK = 3'd3;
  localparam logic [2:0] ST_SCL_STUCK = 3'd4;
  localparam logic [2:0] ST_SDA_STUCK = 3'd5;
  localparam logic [2:0] ST_BAD_LEN   = 3'd6;

  // Longest accepted burst read
  localparam int unsigned MAX_BURST = 16;

  // Reset value of the target address
  localparam logic [6:0] DEV_ADDR_RESET = 7'd106;

  // One result word
  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       done_res;
    logic [2:0] status;
  } res_t;

endpackage

@@ rtl/i2cm_core.sv @@
// ----------------------------------------------------------------------------
// i2cm_core
// Bus sequencer state and its one-word step: closes the current half-period
// and opens the next one.
// ----------------------------------------------------------------------------
module i2cm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [1:0]          kind,
  input  logic [7:0]          reg_addr,
  input  logic [7:0]          write_value,
  input  logic [4:0]          burst_length,
  input  logic                sda_in,
  input  logic                scl_in,
  input  logic [6:0]          dev_addr,
  output i2cm_pkg::res_t      res
);

  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_ST_A  = 5'd1;
  localparam logic [4:0] PH_ST_B  = 5'd2;
  localparam logic [4:0] PH_ST_C  = 5'd3;
  localparam logic [4:0] PH_TX    = 5'd4;
  localparam logic [4:0] PH_TXA_A = 5'd5;
  localparam logic [4:0] PH_TXA_B = 5'd6;
  localparam logic [4:0] PH_TXA_C = 5'd7;
  localparam logic [4:0] PH_RX    = 5'd8;
  localparam logic [4:0] PH_RXA_A = 5'd9;
  localparam logic [4:0] PH_RXA_B = 5'd10;
  localparam logic [4:0] PH_RXA_C = 5'd11;
  localparam logic [4:0] PH_SP_A  = 5'd12;
  localparam logic [4:0] PH_SP_B  = 5'd13;
  localparam logic [4:0] PH_SP_C  = 5'd14;
  localparam logic [4:0] PH_RC_A  = 5'd16;
  localparam logic [4:0] PH_PL_LO = 5'd17;
  localparam logic [4:0] PH_PL_HI = 5'd18;

  localparam logic [3:0] PULSES   = 4'd9;

  logic [4:0] phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [4:0] byte_idx_r, byte_idx_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic [7:0] hreg_r, hreg_nxt;
  logic [7:0] hval_r, hval_nxt;
  logic [4:0] hlen_r, hlen_nxt;
  logic [1:0] pins_r, pins_nxt;
  logic [2:0] seq_r, seq_nxt;
  logic [2:0] pend_r, pend_nxt;

  logic       go_enter;
  logic       go_next;
  logic       ack_bit;
  logic [7:0] addr_byte;
  logic [7:0] rbyte;
  logic       rvalid;
  logic       done;
  logic [2:0] status;

  // Pin levels {scl, sda} for the half-period that a phase opens
  function automatic logic [1:0] pins_for(input logic [4:0] ph, input logic [3:0] bc,
                                          input logic [7:0] sb, input logic ack,
                                          input logic cur_scl);
    logic [1:0] p;
    case (ph)
      PH_ST_B:  p = 2'b10;
      PH_ST_C:  p = 2'b00;
      PH_TX:    p = {bc[0], sb[7]};
      PH_TXA_A,
      PH_TXA_C,
      PH_RXA_C,
      PH_PL_LO: p = 2'b01;
      PH_RX:    p = {~bc[0], 1'b1};
      PH_RXA_A: p = {1'b0, ack};
      PH_RXA_B: p = {1'b1, ack};
      PH_SP_A:  p = {cur_scl, 1'b0};
      PH_SP_B:  p = 2'b10;
      default:  p = 2'b11;
    endcase
    return p;
  endfunction

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    byte_idx_nxt = byte_idx_r;
    cmd_nxt      = cmd_r;
    hreg_nxt     = hreg_r;
    hval_nxt     = hval_r;
    hlen_nxt     = hlen_r;
    pins_nxt     = pins_r;
    seq_nxt      = seq_r;
    pend_nxt     = pend_r;
    go_enter     = 1'b0;
    go_next      = 1'b0;
    rbyte        = 8'd0;
    rvalid       = 1'b0;
    done         = 1'b0;
    status       = i2cm_pkg::ST_OK;
    addr_byte    = {dev_addr, 1'b0};

    if (phase_r == PH_IDLE) begin
      if (kind != i2cm_pkg::KIND_TICK) begin
        if (kind == i2cm_pkg::KIND_READ &&
            (burst_length == 5'd0 ||
             9'(burst_length) > 9'(i2cm_pkg::MAX_BURST))) begin
          done   = 1'b1;
          status = i2cm_pkg::ST_BAD_LEN;
        end else begin
          cmd_nxt      = kind;
          hreg_nxt     = reg_addr;
          hval_nxt     = write_value;
          hlen_nxt     = (kind == i2cm_pkg::KIND_READ) ? burst_length : 5'd0;
          seq_nxt      = 3'd0;
          pend_nxt     = i2cm_pkg::ST_OK;
          byte_idx_nxt = 5'd0;
          bit_cnt_nxt  = 4'd0;
          phase_nxt    = (kind == i2cm_pkg::KIND_RECOVER) ? PH_RC_A : PH_ST_A;
          go_enter     = 1'b1;
        end
      end
    end else if (kind == i2cm_pkg::KIND_TICK) begin
      case (phase_r)
        PH_ST_A: begin
          phase_nxt = PH_ST_B;
          go_enter  = 1'b1;
        end
        PH_ST_B: begin
          phase_nxt = PH_ST_C;
          go_enter  = 1'b1;
        end
        PH_ST_C: go_next = 1'b1;
        PH_TX: begin
          if (bit_cnt_r[0]) begin
            shift_nxt = {shift_r[6:0], 1'b0};
          end
          if (bit_cnt_r == 4'd15) begin
            phase_nxt = PH_TXA_A;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 4'd1;
            phase_nxt   = PH_TX;
          end
          go_enter = 1'b1;
        end
        PH_TXA_A: begin
          phase_nxt = PH_TXA_B;
          go_enter  = 1'b1;
        end
        PH_TXA_B: begin
          if (sda_in) begin
            if (seq_r == 3'd2) begin
              pend_nxt = i2cm_pkg::ST_REG_NACK;
            end else if (seq_r == 3'd3 && cmd_r == i2cm_pkg::KIND_WRITE) begin
              pend_nxt = i2cm_pkg::ST_DATA_NACK;
            end else begin
              pend_nxt = i2cm_pkg::ST_ADDR_NACK;
            end
          end
          phase_nxt = PH_TXA_C;
          go_enter  = 1'b1;
        end
        PH_TXA_C: begin
          if (pend_r != i2cm_pkg::ST_OK) begin
            phase_nxt = PH_SP_A;
            go_enter  = 1'b1;
          end else begin
            go_next = 1'b1;
          end
        end
        PH_RX: begin
          if (!bit_cnt_r[0]) begin
            shift_nxt = {shift_r[6:0], sda_in};
            if (bit_cnt_r == 4'd14) begin
              rbyte  = shift_nxt;
              rvalid = 1'b1;
            end
          end
          if (bit_cnt_r == 4'd15) begin
            phase_nxt = PH_RXA_A;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 4'd1;
            phase_nxt   = PH_RX;
          end
          go_enter = 1'b1;
        end
        PH_RXA_A: begin
          phase_nxt = PH_RXA_B;
          go_enter  = 1'b1;
        end
        PH_RXA_B: begin
          phase_nxt = PH_RXA_C;
          go_enter  = 1'b1;
        end
        PH_RXA_C: begin
          byte_idx_nxt = byte_idx_r + 5'd1;
          if (byte_idx_nxt < hlen_r) begin
            bit_cnt_nxt = 4'd0;
            shift_nxt   = 8'd0;
            phase_nxt   = PH_RX;
            go_enter    = 1'b1;
          end else begin
            go_next = 1'b1;
          end
        end
        PH_SP_A: begin
          phase_nxt = PH_SP_B;
          go_enter  = 1'b1;
        end
        PH_SP_B: begin
          phase_nxt = PH_SP_C;
          go_enter  = 1'b1;
        end
        PH_SP_C: begin
          done = 1'b1;
          if (cmd_r == i2cm_pkg::KIND_RECOVER) begin
            status = !scl_in ? i2cm_pkg::ST_SCL_STUCK :
                     (!sda_in ? i2cm_pkg::ST_SDA_STUCK : i2cm_pkg::ST_OK);
          end else begin
            status = pend_r;
          end
          phase_nxt = PH_IDLE;
        end
        PH_RC_A: begin
          if (!scl_in) begin
            done      = 1'b1;
            status    = i2cm_pkg::ST_SCL_STUCK;
            phase_nxt = PH_IDLE;
          end else begin
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_PL_LO;
            go_enter    = 1'b1;
          end
        end
        PH_PL_LO: begin
          phase_nxt = PH_PL_HI;
          go_enter  = 1'b1;
        end
        PH_PL_HI: begin
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          phase_nxt   = (bit_cnt_nxt < PULSES) ? PH_PL_LO : PH_SP_A;
          go_enter    = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
          pins_nxt  = 2'b11;
        end
      endcase
    end

    // Advance to the next step of the command sequence
    if (go_next) begin
      seq_nxt   = seq_r + 3'd1;
      phase_nxt = PH_SP_A;
      if (cmd_r == i2cm_pkg::KIND_READ) begin
        case (seq_nxt)
          3'd1: begin
            shift_nxt   = addr_byte;
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_TX;
          end
          3'd2: begin
            shift_nxt   = hreg_r;
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_TX;
          end
          3'd3: phase_nxt = PH_ST_A;
          3'd4: begin
            shift_nxt   = addr_byte | 8'd1;
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_TX;
          end
          3'd5: begin
            byte_idx_nxt = 5'd0;
            bit_cnt_nxt  = 4'd0;
            shift_nxt    = 8'd0;
            phase_nxt    = PH_RX;
          end
          default: phase_nxt = PH_SP_A;
        endcase
      end else if (cmd_r == i2cm_pkg::KIND_WRITE) begin
        case (seq_nxt)
          3'd1: begin
            shift_nxt   = addr_byte;
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_TX;
          end
          3'd2: begin
            shift_nxt   = hreg_r;
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_TX;
          end
          3'd3: begin
            shift_nxt   = hval_r;
            bit_cnt_nxt = 4'd0;
            phase_nxt   = PH_TX;
          end
          default: phase_nxt = PH_SP_A;
        endcase
      end
      go_enter = 1'b1;
    end

    // Acknowledge the byte unless it is the last of the burst
    ack_bit = ((6'(byte_idx_nxt) + 6'd1) < 6'(hlen_nxt)) ? 1'b0 : 1'b1;

    if (go_enter) begin
      pins_nxt = pins_for(phase_nxt, bit_cnt_nxt, shift_nxt, ack_bit, pins_r[1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= 4'd0;
      shift_r    <= 8'd0;
      byte_idx_r <= 5'd0;
      cmd_r      <= 2'd0;
      hreg_r     <= 8'd0;
      hval_r     <= 8'd0;
      hlen_r     <= 5'd0;
      pins_r     <= 2'b11;
      seq_r      <= 3'd0;
      pend_r     <= i2cm_pkg::ST_OK;
    end else if (step) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      byte_idx_r <= byte_idx_nxt;
      cmd_r      <= cmd_nxt;
      hreg_r     <= hreg_nxt;
      hval_r     <= hval_nxt;
      hlen_r     <= hlen_nxt;
      pins_r     <= pins_nxt;
      seq_r      <= seq_nxt;
      pend_r     <= pend_nxt;
    end
  end

  assign res.scl_release = pins_nxt[1];
  assign res.sda_release = pins_nxt[0];
  assign res.busy_res    = (phase_nxt != PH_IDLE);
  assign res.read_byte   = rbyte;
  assign res.byte_valid  = rvalid;
  assign res.done_res    = done;
  assign res.status      = status;

endmodule

@@ rtl/i2c_master_register_access_top.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_access_top
// Open-drain I2C master for burst register reads, register writes and bus
// recovery, stepped one bus half-period per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): each word is either a command (burst read, register
//   write, bus recovery), taken only while the sequencer is idle, or a tick
//   that closes the current half-period with the sampled SCL/SDA levels.
//   A command that arrives while busy is dropped and just reports the pins.
//   Result channel (out_*): exactly one word per input word, in order, with
//   the pin releases for the next half-period, any received byte, done and
//   status.
//   Config channel (cfg_*): 7-bit target address; write it only while idle.
//   Output: registered, shown in the cycle after its input word is accepted.
//   Throughput: one word per cycle while out_ready keeps up; the step is a
//   single pass of logic between the sequencer state and the result register.
//   Stall: the result register holds while out_ready is low; in_ready drops
//   only when that register is full and not being drained.
//   Reset: sequencer idle, both lines released, address back to 106.
// ----------------------------------------------------------------------------
module i2c_master_register_access_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_reg_addr,
  input  logic [7:0] in_write_value,
  input  logic [4:0] in_burst_length,
  input  logic       in_sda_in,
  input  logic       in_scl_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_release,
  output logic       out_sda_release,
  output logic       out_busy_res,
  output logic [7:0] out_read_byte,
  output logic       out_byte_valid,
  output logic       out_done_res,
  output logic [2:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_device_address
);

  logic           step;
  logic [6:0]     dev_addr_r;
  logic           out_valid_r;
  i2cm_pkg::res_t res;
  i2cm_pkg::res_t res_r;

  // Accept a word whenever the result slot is free or draining this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= i2cm_pkg::DEV_ADDR_RESET;
    end else if (cfg_valid) begin
      dev_addr_r <= cfg_device_address;
    end
  end

  i2cm_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .kind         (in_kind),
    .reg_addr     (in_reg_addr),
    .write_value  (in_write_value),
    .burst_length (in_burst_length),
    .sda_in       (in_sda_in),
    .scl_in       (in_scl_in),
    .dev_addr     (dev_addr_r),
    .res          (res)
  );

  // Result register: load on accept, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl_release = res_r.scl_release;
  assign out_sda_release = res_r.sda_release;
  assign out_busy_res    = res_r.busy_res;
  assign out_read_byte   = res_r.read_byte;
  assign out_byte_valid  = res_r.byte_valid;
  assign out_done_res    = res_r.done_res;
  assign out_status      = res_r.status;

  // A status other than ok comes only with done
  a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.done_res |-> res_r.status == i2cm_pkg::ST_OK)
    else $error("status set without done");

  // Done leaves the sequencer idle and never carries a received byte
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> !res_r.busy_res && !res_r.byte_valid)
    else $error("done word still busy or carrying a byte");

  // A received byte shows up only mid-command
  a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.byte_valid |-> res_r.busy_res)
    else $error("byte valid while idle");

  // Read data stays zero when no byte completes
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.byte_valid |-> res_r.read_byte == 8'd0)
    else $error("read byte nonzero without byte valid");

  // Back-pressure only comes from a full, stalled result register
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r && !out_ready)
    else $error("input stalled without output stall");

endmodule

@@ tb/i2c_seq_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_seq_check_pkg
// Bus word type and a word-exact model of the I2C register access sequencer,
// kept in a small scoreboard that predicts and checks result words.
// ----------------------------------------------------------------------------
package i2c_seq_check_pkg;

  // Sequencer phases, one per bus half-period kind
  typedef enum logic [4:0] {
    BP_IDLE, BP_START1, BP_START2, BP_START3, BP_SEND, BP_SACK1, BP_SACK2, BP_SACK3,
    BP_RECV, BP_MACK1, BP_MACK2, BP_MACK3, BP_STOP1, BP_STOP2, BP_STOP3,
    BP_RCHK, BP_PULSE_LO, BP_PULSE_HI
  } bus_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] reg_addr;
    logic [7:0] write_value;
    logic [4:0] burst_length;
    logic       sda_in;
    logic       scl_in;
  } bus_word_t;

  class i2c_seq_scoreboard;
    logic [6:0] dev_addr;
    bus_phase_t phase;
    logic [3:0] bit_cnt;
    logic [7:0] shreg;
    logic [4:0] byte_idx;
    logic [1:0] cmd;
    logic [7:0] h_reg;
    logic [7:0] h_val;
    logic [4:0] h_len;
    logic       scl_pin;
    logic       sda_pin;
    logic [2:0] seq_pos;
    logic [2:0] pend_st;

    i2cm_pkg::res_t awaited_words[$];
    int   mismatches;
    int   words_checked;
    int   bytes_read;
    int   endings[8];

    function new();
      dev_addr = i2cm_pkg::DEV_ADDR_RESET;
      phase    = BP_IDLE;
      bit_cnt  = '0;
      shreg    = '0;
      byte_idx = '0;
      cmd      = i2cm_pkg::KIND_TICK;
      h_reg    = '0;
      h_val    = '0;
      h_len    = '0;
      scl_pin  = 1'b1;
      sda_pin  = 1'b1;
      seq_pos  = '0;
      pend_st  = i2cm_pkg::ST_OK;
      mismatches = 0;
      words_checked = 0;
      bytes_read = 0;
      foreach (endings[i]) endings[i] = 0;
    endfunction

    function void set_device_address(logic [6:0] a);
      dev_addr = a;
    endfunction

    // Open a half-period and set the line releases it holds
    function void enter(bus_phase_t p);
      logic ackbit;
      ackbit = (({1'b0, byte_idx} + 6'd1) < {1'b0, h_len}) ? 1'b0 : 1'b1;
      phase = p;
      case (p)
        BP_START2: begin scl_pin = 1'b1; sda_pin = 1'b0; end
        BP_START3: begin scl_pin = 1'b0; sda_pin = 1'b0; end
        BP_SEND: begin scl_pin = bit_cnt[0]; sda_pin = shreg[7]; end
        BP_SACK1, BP_SACK3, BP_MACK3, BP_PULSE_LO: begin
          scl_pin = 1'b0;
          sda_pin = 1'b1;
        end
        BP_RECV: begin scl_pin = ~bit_cnt[0]; sda_pin = 1'b1; end
        BP_MACK1: begin scl_pin = 1'b0; sda_pin = ackbit; end
        BP_MACK2: begin scl_pin = 1'b1; sda_pin = ackbit; end
        BP_STOP1: sda_pin = 1'b0;
        BP_STOP2: begin scl_pin = 1'b1; sda_pin = 1'b0; end
        default: begin scl_pin = 1'b1; sda_pin = 1'b1; end
      endcase
    endfunction

    function void load_byte(logic [7:0] v);
      shreg = v;
      bit_cnt = '0;
      enter(BP_SEND);
    endfunction

    // Advance to the next byte, repeated start or receive of the command, or to the stop
    function void next_job();
      logic [7:0] addr_w;
      addr_w = {dev_addr, 1'b0};
      seq_pos = seq_pos + 3'd1;
      if (cmd == i2cm_pkg::KIND_READ) begin
        case (seq_pos)
          3'd1: begin load_byte(addr_w); return; end
          3'd2: begin load_byte(h_reg); return; end
          3'd3: begin enter(BP_START1); return; end
          3'd4: begin load_byte(addr_w | 8'h01); return; end
          3'd5: begin
            byte_idx = '0;
            bit_cnt = '0;
            shreg = '0;
            enter(BP_RECV);
            return;
          end
          default: ;
        endcase
      end else if (cmd == i2cm_pkg::KIND_WRITE) begin
        case (seq_pos)
          3'd1: begin load_byte(addr_w); return; end
          3'd2: begin load_byte(h_reg); return; end
          3'd3: begin load_byte(h_val); return; end
          default: ;
        endcase
      end
      enter(BP_STOP1);
    endfunction

    function logic [2:0] nack_status();
      if (seq_pos == 3'd2) return i2cm_pkg::ST_REG_NACK;
      if (seq_pos == 3'd3 && cmd == i2cm_pkg::KIND_WRITE) return i2cm_pkg::ST_DATA_NACK;
      return i2cm_pkg::ST_ADDR_NACK;
    endfunction

    // One accepted word: close the running half-period, open the next
    function i2cm_pkg::res_t step_sequencer(bus_word_t w);
      i2cm_pkg::res_t r;
      r = '0;
      if (phase == BP_IDLE) begin
        if (w.kind != i2cm_pkg::KIND_TICK) begin
          if (w.kind == i2cm_pkg::KIND_READ &&
              (w.burst_length == 0 || w.burst_length > i2cm_pkg::MAX_BURST)) begin
            r.done_res = 1'b1;
            r.status = i2cm_pkg::ST_BAD_LEN;
          end else begin
            cmd = w.kind;
            h_reg = w.reg_addr;
            h_val = w.write_value;
            h_len = (w.kind == i2cm_pkg::KIND_READ) ? w.burst_length : 5'd0;
            seq_pos = '0;
            pend_st = i2cm_pkg::ST_OK;
            byte_idx = '0;
            bit_cnt = '0;
            enter(w.kind == i2cm_pkg::KIND_RECOVER ? BP_RCHK : BP_START1);
          end
        end
      end else if (w.kind == i2cm_pkg::KIND_TICK) begin
        case (phase)
          BP_START1: enter(BP_START2);
          BP_START2: enter(BP_START3);
          BP_START3: next_job();
          BP_SEND: begin
            if (bit_cnt[0]) shreg = shreg << 1;
            if (bit_cnt == 4'd15) begin
              enter(BP_SACK1);
            end else begin
              bit_cnt = bit_cnt + 4'd1;
              enter(BP_SEND);
            end
          end
          BP_SACK1: enter(BP_SACK2);
          BP_SACK2: begin
            if (w.sda_in) pend_st = nack_status();
            enter(BP_SACK3);
          end
          BP_SACK3: begin
            if (pend_st != i2cm_pkg::ST_OK) enter(BP_STOP1);
            else next_job();
          end
          BP_RECV: begin
            if (!bit_cnt[0]) begin
              shreg = {shreg[6:0], w.sda_in};
              if (bit_cnt == 4'd14) begin
                r.read_byte = shreg;
                r.byte_valid = 1'b1;
              end
            end
            if (bit_cnt == 4'd15) begin
              enter(BP_MACK1);
            end else begin
              bit_cnt = bit_cnt + 4'd1;
              enter(BP_RECV);
            end
          end
          BP_MACK1: enter(BP_MACK2);
          BP_MACK2: enter(BP_MACK3);
          BP_MACK3: begin
            byte_idx = byte_idx + 5'd1;
            if (byte_idx < h_len) begin
              bit_cnt = '0;
              shreg = '0;
              enter(BP_RECV);
            end else begin
              next_job();
            end
          end
          BP_STOP1: enter(BP_STOP2);
          BP_STOP2: enter(BP_STOP3);
          BP_STOP3: begin
            r.done_res = 1'b1;
            if (cmd == i2cm_pkg::KIND_RECOVER)
              r.status = !w.scl_in ? i2cm_pkg::ST_SCL_STUCK :
                         (!w.sda_in ? i2cm_pkg::ST_SDA_STUCK : i2cm_pkg::ST_OK);
            else
              r.status = pend_st;
            phase = BP_IDLE;
          end
          BP_RCHK: begin
            if (!w.scl_in) begin
              r.done_res = 1'b1;
              r.status = i2cm_pkg::ST_SCL_STUCK;
              phase = BP_IDLE;
            end else begin
              bit_cnt = '0;
              enter(BP_PULSE_LO);
            end
          end
          BP_PULSE_LO: enter(BP_PULSE_HI);
          BP_PULSE_HI: begin
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < 4'd9) enter(BP_PULSE_LO);
            else enter(BP_STOP1);
          end
          default: begin
            phase = BP_IDLE;
            scl_pin = 1'b1;
            sda_pin = 1'b1;
          end
        endcase
      end
      r.scl_release = scl_pin;
      r.sda_release = sda_pin;
      r.busy_res = (phase != BP_IDLE);
      return r;
    endfunction

    function void note_input(bus_word_t w);
      i2cm_pkg::res_t want;
      want = step_sequencer(w);
      if (want.done_res) endings[want.status]++;
      if (want.byte_valid) bytes_read++;
      awaited_words.push_back(want);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(i2cm_pkg::res_t got);
      i2cm_pkg::res_t want;
      if (awaited_words.size() == 0) begin
        mismatches++;
        $display("%0t: result word arrived with nothing awaited", $time);
        return;
      end
      want = awaited_words.pop_front();
      words_checked++;
      compare_field("scl_release", want.scl_release, got.scl_release);
      compare_field("sda_release", want.sda_release, got.sda_release);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("read_byte", want.read_byte, got.read_byte);
      compare_field("byte_valid", want.byte_valid, got.byte_valid);
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

endpackage

@@ tb/i2c_master_register_access_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_register_access_top_tb
// Drives tick and command words into the I2C register access master, acting
// as the bus slave on the sampled pins, and checks every result word against
// a word-exact model held in the scoreboard. Runs directed commands first,
// then random command sequences under several target addresses.
// ----------------------------------------------------------------------------
module i2c_master_register_access_top_tb;

  // Which acknowledge of a command the slave refuses; the third one is the
  // data byte of a write or the address+read byte of a burst
  localparam int ACK_NONE  = 0;
  localparam int ACK_ADDR  = 1;
  localparam int ACK_REG   = 2;
  localparam int ACK_THIRD = 3;

  localparam int          SETTLE_CYCLES = 4;
  localparam int          LONG_HOLD     = 120;
  localparam int          PHASE_WORDS   = 100;
  localparam int unsigned CYCLE_LIMIT   = 800000;

  typedef enum int {RC_CLEAN, RC_SCL_EARLY, RC_SCL_LATE, RC_SDA_LATE} recovery_fault_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_kind = i2cm_pkg::KIND_TICK;
  logic [7:0] in_reg_addr = '0;
  logic [7:0] in_write_value = '0;
  logic [4:0] in_burst_length = '0;
  logic       in_sda_in = 1'b1;
  logic       in_scl_in = 1'b1;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_scl_release;
  logic       out_sda_release;
  logic       out_busy_res;
  logic [7:0] out_read_byte;
  logic       out_byte_valid;
  logic       out_done_res;
  logic [2:0] out_status;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_device_address = i2cm_pkg::DEV_ADDR_RESET;

  i2c_seq_check_pkg::i2c_seq_scoreboard sb;
  int          words_sent = 0;
  bit          sender_calm = 1'b0;
  int unsigned cycle_count = 0;

  // Receiver pacing state, owned by the result sink
  int rx_hold_left = 0;
  int rx_calm_left = 0;
  bit long_hold_done = 1'b0;

  i2c_master_register_access_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_reg_addr        (in_reg_addr),
    .in_write_value     (in_write_value),
    .in_burst_length    (in_burst_length),
    .in_sda_in          (in_sda_in),
    .in_scl_in          (in_scl_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_scl_release    (out_scl_release),
    .out_sda_release    (out_sda_release),
    .out_busy_res       (out_busy_res),
    .out_read_byte      (out_read_byte),
    .out_byte_valid     (out_byte_valid),
    .out_done_res       (out_done_res),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_device_address (cfg_device_address)
  );

  always #6 clk = ~clk;

  // Stop a hung run; the limit is far above the slowest legal run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at cycle limit with %0d words awaited", sb.awaited_words.size());
      $display("i2c_master_register_access_top: mismatch");
      $finish;
    end
  end

  // Result sink: check each accepted word, then pick out_ready for the next
  // cycle. Mix short stalls, a few long ones and calm stretches, and hold off
  // once for a long stretch so the result register fills and in_ready drops.
  always @(posedge clk) begin : result_sink
    i2cm_pkg::res_t got;
    int   r;
    if (rst_n && out_valid && out_ready) begin
      got = {out_scl_release, out_sda_release, out_busy_res, out_read_byte,
             out_byte_valid, out_done_res, out_status};
      sb.check_result(got);
    end
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_ready <= 1'b0;
    end else if (!long_hold_done && sb.words_checked >= 1200) begin
      long_hold_done = 1'b1;
      rx_hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (rx_calm_left > 0) begin
      rx_calm_left = rx_calm_left - 1;
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        rx_calm_left = $urandom_range(50, 200);
        out_ready <= 1'b1;
      end else if (r < 22) begin
        rx_hold_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else if (r < 24) begin
        rx_hold_left = $urandom_range(9, 29);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Favor the byte extremes now and then
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic i2c_seq_check_pkg::bus_word_t random_word();
    i2c_seq_check_pkg::bus_word_t w;
    w.kind = 2'($urandom_range(0, 3));
    w.reg_addr = pick_byte();
    w.write_value = pick_byte();
    w.burst_length = 5'($urandom_range(0, 31));
    w.sda_in = 1'($urandom_range(0, 1));
    w.scl_in = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Offer one word, hold it until taken, then note it in the scoreboard.
  // Only words the block acts on count toward the run length.
  task automatic send_word(input i2c_seq_check_pkg::bus_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= w.kind;
    in_reg_addr <= w.reg_addr;
    in_write_value <= w.write_value;
    in_burst_length <= w.burst_length;
    in_sda_in <= w.sda_in;
    in_scl_in <= w.scl_in;
    do @(posedge clk); while (!in_ready);
    if ((sb.phase == i2c_seq_check_pkg::BP_IDLE) ? (w.kind != i2cm_pkg::KIND_TICK) :
        (w.kind == i2cm_pkg::KIND_TICK))
      words_sent++;
    sb.note_input(w);
  endtask

  // Drop valid and wait out every awaited word plus the block's latency
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (sb.awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_device_address(input logic [6:0] a);
    cfg_valid <= 1'b1;
    cfg_device_address <= a;
    do @(posedge clk); while (!cfg_ready);
    sb.set_device_address(a);
    cfg_valid <= 1'b0;
  endtask

  // Issue one command and play the slave until the sequencer is idle again.
  // Acknowledge every sent byte except the chosen one, feed random data on
  // reads, and shape the recovery line checks by the chosen fault. Now and
  // then offer a command while busy; the block must drop it.
  task automatic run_command(input logic [1:0] kind, input logic [7:0] reg_addr,
                             input logic [7:0] value, input logic [4:0] len,
                             input int nack_ack, input recovery_fault_t fault,
                             input int noise_pct);
    i2c_seq_check_pkg::bus_word_t w;
    int ack_no;
    ack_no = 0;
    sender_calm = ($urandom_range(0, 99) < 15);
    w = random_word();
    w.kind = kind;
    w.reg_addr = reg_addr;
    w.write_value = value;
    w.burst_length = len;
    send_word(w);
    while (sb.phase != i2c_seq_check_pkg::BP_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        w = random_word();
        w.kind = 2'($urandom_range(1, 3));
        send_word(w);
      end
      w = random_word();
      w.kind = i2cm_pkg::KIND_TICK;
      case (sb.phase)
        i2c_seq_check_pkg::BP_SACK2: begin
          ack_no++;
          w.sda_in = (ack_no == nack_ack) ? 1'b1 : 1'b0;
        end
        i2c_seq_check_pkg::BP_RCHK: w.scl_in = (fault == RC_SCL_EARLY) ? 1'b0 : 1'b1;
        i2c_seq_check_pkg::BP_STOP3: begin
          if (kind == i2cm_pkg::KIND_RECOVER) begin
            w.scl_in = (fault == RC_SCL_LATE) ? 1'b0 : 1'b1;
            w.sda_in = (fault == RC_SDA_LATE) ? 1'b0 : 1'b1;
          end
        end
        default: ;
      endcase
      send_word(w);
    end
  endtask

  // Mostly short bursts, a few full-length and a few rejected lengths
  task automatic run_random_command();
    i2c_seq_check_pkg::bus_word_t w;
    logic [1:0]      kind;
    logic [4:0]      len;
    int              nack_ack;
    int              r;
    recovery_fault_t fault;
    if ($urandom_range(0, 99) < 5) begin
      w = random_word();
      w.kind = i2cm_pkg::KIND_TICK;
      send_word(w);
    end
    r = $urandom_range(0, 99);
    kind = (r < 45) ? i2cm_pkg::KIND_READ :
           ((r < 80) ? i2cm_pkg::KIND_WRITE : i2cm_pkg::KIND_RECOVER);
    r = $urandom_range(0, 99);
    if (kind != i2cm_pkg::KIND_READ) len = 5'($urandom_range(0, 31));
    else if (r < 5) len = ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(17, 31));
    else if (r < 10) len = 5'(i2cm_pkg::MAX_BURST);
    else if (r < 28) len = 5'($urandom_range(5, 15));
    else len = 5'($urandom_range(1, 4));
    nack_ack = ($urandom_range(0, 99) < 20) ? $urandom_range(ACK_ADDR, ACK_THIRD) : ACK_NONE;
    r = $urandom_range(0, 99);
    if (r < 70) fault = RC_CLEAN;
    else if (r < 80) fault = RC_SCL_EARLY;
    else if (r < 90) fault = RC_SCL_LATE;
    else fault = RC_SDA_LATE;
    run_command(kind, pick_byte(), pick_byte(), len, nack_ack, fault, 3);
  endtask

  initial begin : stimulus
    i2c_seq_check_pkg::bus_word_t w;
    logic [6:0] addr_plan[5];
    int         goal;
    sb = new();
    addr_plan = '{7'h7F, 7'h00, 7'($urandom_range(1, 126)), 7'h55,
                  i2cm_pkg::DEV_ADDR_RESET};

    // Hold reset once, then release it
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ticks while idle, rejected lengths, every command kind,
    // each refused acknowledge and each recovery line fault
    w = '0;
    w.kind = i2cm_pkg::KIND_TICK;
    send_word(w);
    w.sda_in = 1'b1;
    w.scl_in = 1'b1;
    send_word(w);
    run_command(i2cm_pkg::KIND_READ, 8'h10, 8'h00, 5'd0, ACK_NONE, RC_CLEAN, 0);
    run_command(i2cm_pkg::KIND_READ, 8'h10, 8'h00, 5'd17, ACK_NONE, RC_CLEAN, 0);
    run_command(i2cm_pkg::KIND_READ, 8'h10, 8'h00, 5'd31, ACK_NONE, RC_CLEAN, 0);
    run_command(i2cm_pkg::KIND_WRITE, 8'h00, 8'hFF, 5'd0, ACK_NONE, RC_CLEAN, 50);
    run_command(i2cm_pkg::KIND_WRITE, 8'hFF, 8'h00, 5'd31, ACK_THIRD, RC_CLEAN, 0);
    run_command(i2cm_pkg::KIND_WRITE, 8'h5A, 8'hA5, 5'd1, ACK_REG, RC_CLEAN, 0);
    run_command(i2cm_pkg::KIND_WRITE, 8'h33, 8'hCC, 5'd1, ACK_ADDR, RC_CLEAN, 0);
    run_command(i2cm_pkg::KIND_READ, 8'hA5, 8'h00, 5'd1, ACK_ADDR, RC_CLEAN, 0);
    run_command(i2cm_pkg::KIND_READ, 8'h01, 8'h00, 5'd1, ACK_REG, RC_CLEAN, 0);
    run_command(i2cm_pkg::KIND_READ, 8'hFE, 8'h00, 5'd2, ACK_THIRD, RC_CLEAN, 0);
    run_command(i2cm_pkg::KIND_READ, 8'h00, 8'h00, 5'd1, ACK_NONE, RC_CLEAN, 0);
    run_command(i2cm_pkg::KIND_READ, 8'hFF, 8'hFF, 5'(i2cm_pkg::MAX_BURST), ACK_NONE,
                RC_CLEAN, 0);
    run_command(i2cm_pkg::KIND_RECOVER, 8'h00, 8'h00, 5'd0, ACK_NONE, RC_CLEAN, 0);
    run_command(i2cm_pkg::KIND_RECOVER, 8'h00, 8'h00, 5'd0, ACK_NONE, RC_SCL_EARLY, 0);
    run_command(i2cm_pkg::KIND_RECOVER, 8'h00, 8'h00, 5'd0, ACK_NONE, RC_SCL_LATE, 0);
    run_command(i2cm_pkg::KIND_RECOVER, 8'h00, 8'h00, 5'd0, ACK_NONE, RC_SDA_LATE, 0);

    // Random phases, each under its own target address. Pause the sender
    // until every awaited word is in before touching the address.
    foreach (addr_plan[k]) begin
      settle_idle();
      write_device_address(addr_plan[k]);
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) run_random_command();
    end

    settle_idle();
    $display("covered %0d words (%0d checked), %0d bytes read, %0d clean endings",
             words_sent, sb.words_checked, sb.bytes_read, sb.endings[i2cm_pkg::ST_OK]);
    $display("nack endings %0d/%0d/%0d, stuck scl/sda %0d/%0d, bad length %0d",
             sb.endings[i2cm_pkg::ST_ADDR_NACK], sb.endings[i2cm_pkg::ST_REG_NACK],
             sb.endings[i2cm_pkg::ST_DATA_NACK], sb.endings[i2cm_pkg::ST_SCL_STUCK],
             sb.endings[i2cm_pkg::ST_SDA_STUCK], sb.endings[i2cm_pkg::ST_BAD_LEN]);
    if (sb.mismatches == 0 && sb.awaited_words.size() == 0) begin
      $display("i2c_master_register_access_top: match");
    end else begin
      $display("i2c_master_register_access_top: mismatch");
    end
    $finish;
  end

endmodule
